@@ src/bfpa_pkg.sv @@
`timescale 1ns / 1ps
package bfpa_pkg;
   localparam int MAX_BLOCKS_DEF = 16;
   localparam int ADDR_BITS_DEF  = 16;
   localparam int OWNER_BITS_DEF = 8;
   localparam int CODE_BITS      = 3;
   localparam logic [15:0] MEM_SIZE_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      MODE_REQUEST = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_COMPACT = 2'd2,
      MODE_STATUS  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      RC_OK       = 3'd0,
      RC_NO_FIT   = 3'd1,
      RC_NO_OWNER = 3'd2,
      RC_BAD_SIZE = 3'd3,
      RC_FULL     = 3'd4
   } code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_MERGE,
      ST_COMPACT,
      ST_TOTAL,
      ST_DUMP,
      ST_EMIT
   } state_type;
endpackage

@@ src/bfpa_if.sv @@
`timescale 1ns / 1ps
interface bfpa_req_if #(parameter int AW = 16, parameter int OW = 8);
   logic          valid;
   logic          ready;
   logic [1:0]    mode;
   logic [OW-1:0] owner_id;
   logic [AW-1:0] request_size;
   modport source (output valid, mode, owner_id, request_size, input ready);
   modport sink   (input valid, mode, owner_id, request_size, output ready);
endinterface

interface bfpa_rsp_if #(parameter int AW = 16, parameter int OW = 8);
   logic          valid;
   logic          ready;
   logic [2:0]    result_code;
   logic [AW-1:0] block_start;
   logic [AW-1:0] block_length;
   logic          block_is_hole;
   logic [OW-1:0] block_holder;
   logic [AW-1:0] alloc_bytes;
   logic [AW-1:0] hole_bytes;
   logic          last;
   modport source (output valid, result_code, block_start, block_length, block_is_hole,
                   block_holder, alloc_bytes, hole_bytes, last, input ready);
   modport sink   (input valid, result_code, block_start, block_length, block_is_hole,
                   block_holder, alloc_bytes, hole_bytes, last, output ready);
endinterface

interface bfpa_csr_if #(parameter int AW = 16);
   logic          valid;
   logic          ready;
   logic [AW-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ src/best_fit_partition_allocator.sv @@
`timescale 1ns / 1ps
// Channel | Dir | Payload
// req     | in  | mode, owner_id, request_size
// rsp     | out | result_code, block_start, block_length, block_is_hole,
//         |     | block_holder, alloc_bytes, hole_bytes, last
// csr     | in  | memory_size write data
// One item at a time under a small sequencer; the table sits in flip-flop entries.
// Request: scan every entry, then shift the entries above the chosen one up by one slot.
// Release: scan to the owner, then a merge pass over the table; each merge
// (at most two) moves the entries above it down. Compact: one pass, then the trailing hole.
// Status: one totals pass, then one result per entry.
// Synchronous reset leaves one hole of 65535 bytes; rsp stalls hold the result.
module best_fit_partition_allocator #(
   parameter int MAX_BLOCKS = bfpa_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_BITS  = bfpa_pkg::ADDR_BITS_DEF,
   parameter int OWNER_BITS = bfpa_pkg::OWNER_BITS_DEF
) (
   input logic clock,
   input logic reset,
   bfpa_req_if.sink   req,
   bfpa_rsp_if.source rsp,
   bfpa_csr_if.sink   csr
);
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

   logic [ADDR_BITS-1:0]  st_ff [MAX_BLOCKS];
   logic [ADDR_BITS-1:0]  sz_ff [MAX_BLOCKS];
   logic                  fr_ff [MAX_BLOCKS];
   logic [OWNER_BITS-1:0] ow_ff [MAX_BLOCKS];
   logic [CW-1:0] cnt_ff;
   logic [ADDR_BITS-1:0] msize_ff;

   bfpa_pkg::state_type state_ff, state_in;
   bfpa_pkg::mode_type  mode_ff;
   logic [OWNER_BITS-1:0] own_ff;
   logic [ADDR_BITS-1:0]  rsz_ff;
   logic [CW-1:0] i_ff;       // scan/read index
   logic [CW-1:0] j_ff;       // write index (compact), shift target, merge move index
   logic found_ff;
   logic [IW-1:0] best_ff;
   logic [ADDR_BITS-1:0] left_ff, acc_ff, fre_ff, alc_ff;

   // output register
   logic ov_ff;
   logic [2:0] oc_ff;
   logic [ADDR_BITS-1:0] os_ff, ol_ff, oa_ff, of_ff;
   logic oh_ff, olast_ff;
   logic [OWNER_BITS-1:0] oo_ff;

   logic [IW-1:0] ii;
   logic [IW-1:0] jj;
   logic [ADDR_BITS:0] diff;
   logic fit;
   logic out_free;
   assign ii = i_ff[IW-1:0];
   assign jj = j_ff[IW-1:0];
   assign out_free = !ov_ff || rsp.ready;
   // subtract/compare unit for the best-fit scan
   assign diff = {1'b0, sz_ff[ii]} - {1'b0, rsz_ff};
   assign fit  = fr_ff[ii] && !diff[ADDR_BITS];

   assign req.ready = (state_ff == bfpa_pkg::ST_IDLE) && !ov_ff;
   assign csr.ready = 1'b1;

   assign rsp.valid = ov_ff;
   assign rsp.result_code = oc_ff;
   assign rsp.block_start = os_ff;
   assign rsp.block_length = ol_ff;
   assign rsp.block_is_hole = oh_ff;
   assign rsp.block_holder = oo_ff;
   assign rsp.alloc_bytes = oa_ff;
   assign rsp.hole_bytes = of_ff;
   assign rsp.last = olast_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfpa_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               unique case (bfpa_pkg::mode_type'(req.mode))
                  bfpa_pkg::MODE_REQUEST: state_in = (req.request_size == '0) ?
                                            bfpa_pkg::ST_EMIT : bfpa_pkg::ST_SCAN;
                  bfpa_pkg::MODE_RELEASE: state_in = bfpa_pkg::ST_SCAN;
                  bfpa_pkg::MODE_COMPACT: state_in = bfpa_pkg::ST_COMPACT;
                  default:                state_in = bfpa_pkg::ST_TOTAL;
               endcase
            end
         end
         bfpa_pkg::ST_SCAN: begin
            if (i_ff == cnt_ff) begin
               state_in = bfpa_pkg::ST_EMIT;
               if (mode_ff == bfpa_pkg::MODE_REQUEST && found_ff && left_ff != '0 &&
                   cnt_ff != MAXC)
                  state_in = bfpa_pkg::ST_SHIFT;
            end else if (mode_ff == bfpa_pkg::MODE_RELEASE && !fr_ff[ii] &&
                         ow_ff[ii] == own_ff) begin
               state_in = bfpa_pkg::ST_MERGE;
            end
         end
         bfpa_pkg::ST_SHIFT:
            if (j_ff == CW'(best_ff) + CW'(1)) state_in = bfpa_pkg::ST_EMIT;
         bfpa_pkg::ST_MERGE:
            if (j_ff == '0 && i_ff + CW'(1) >= cnt_ff) state_in = bfpa_pkg::ST_EMIT;
         bfpa_pkg::ST_COMPACT:
            if (i_ff == cnt_ff) state_in = bfpa_pkg::ST_EMIT;
         bfpa_pkg::ST_TOTAL:
            if (i_ff == cnt_ff) state_in = bfpa_pkg::ST_DUMP;
         bfpa_pkg::ST_DUMP:
            if (out_free && i_ff + CW'(1) == cnt_ff) state_in = bfpa_pkg::ST_IDLE;
         bfpa_pkg::ST_EMIT:
            if (out_free) state_in = bfpa_pkg::ST_IDLE;
         default: state_in = bfpa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bfpa_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // datapath and table updates
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= CW'(1);
         msize_ff <= ADDR_BITS'(bfpa_pkg::MEM_SIZE_RESET);
         st_ff[0] <= '0;
         sz_ff[0] <= ADDR_BITS'(bfpa_pkg::MEM_SIZE_RESET);
         fr_ff[0] <= 1'b1;
         ow_ff[0] <= '0;
         ov_ff    <= 1'b0;
      end else begin
         // the dump state reloads the output register itself
         if (ov_ff && rsp.ready && state_ff != bfpa_pkg::ST_DUMP) ov_ff <= 1'b0;
         if (csr.valid && csr.data != '0) begin
            // to be written only while idle, which the block does not enforce: reload table as one hole
            msize_ff <= csr.data;
            cnt_ff   <= CW'(1);
            st_ff[0] <= '0;
            sz_ff[0] <= csr.data;
            fr_ff[0] <= 1'b1;
            ow_ff[0] <= '0;
         end
         unique case (state_ff)
            bfpa_pkg::ST_IDLE: begin
               if (req.valid && req.ready) begin
                  mode_ff  <= bfpa_pkg::mode_type'(req.mode);
                  own_ff   <= req.owner_id;
                  rsz_ff   <= req.request_size;
                  i_ff     <= '0;
                  j_ff     <= '0;
                  found_ff <= 1'b0;
                  acc_ff   <= '0;
                  fre_ff   <= '0;
                  alc_ff   <= '0;
                  oc_ff    <= bfpa_pkg::RC_BAD_SIZE;
                  os_ff <= '0; ol_ff <= '0; oh_ff <= 1'b0; oo_ff <= '0;
                  oa_ff <= '0; of_ff <= '0; olast_ff <= 1'b1;
               end
            end
            bfpa_pkg::ST_SCAN: begin
               if (i_ff == cnt_ff) begin
                  if (mode_ff == bfpa_pkg::MODE_RELEASE) begin
                     oc_ff <= bfpa_pkg::RC_NO_OWNER;
                  end else if (!found_ff) begin
                     oc_ff <= bfpa_pkg::RC_NO_FIT;
                  end else if (left_ff != '0 && cnt_ff == MAXC) begin
                     oc_ff <= bfpa_pkg::RC_FULL;
                  end else begin
                     oc_ff <= bfpa_pkg::RC_OK;
                     os_ff <= st_ff[best_ff];
                     ol_ff <= rsz_ff;
                     oo_ff <= own_ff;
                     fr_ff[best_ff] <= 1'b0;
                     ow_ff[best_ff] <= own_ff;
                     if (left_ff != '0) begin
                        sz_ff[best_ff] <= rsz_ff;
                        j_ff <= cnt_ff;
                        cnt_ff <= cnt_ff + CW'(1);
                     end
                  end
               end else if (mode_ff == bfpa_pkg::MODE_REQUEST) begin
                  i_ff <= i_ff + CW'(1);
                  if (fit && (!found_ff || diff[ADDR_BITS-1:0] < left_ff)) begin
                     found_ff <= 1'b1;
                     best_ff  <= ii;
                     left_ff  <= diff[ADDR_BITS-1:0];
                  end
               end else if (!fr_ff[ii] && ow_ff[ii] == own_ff) begin
                  oc_ff <= bfpa_pkg::RC_OK;
                  os_ff <= st_ff[ii];
                  ol_ff <= sz_ff[ii];
                  oh_ff <= 1'b1;
                  fr_ff[ii] <= 1'b1;
                  ow_ff[ii] <= '0;
                  i_ff <= '0;
               end else begin
                  i_ff <= i_ff + CW'(1);
               end
            end
            bfpa_pkg::ST_SHIFT: begin
               // move one entry up per cycle, then drop in the new hole
               if (j_ff == CW'(best_ff) + CW'(1)) begin
                  st_ff[jj] <= st_ff[best_ff] + rsz_ff;
                  sz_ff[jj] <= left_ff;
                  fr_ff[jj] <= 1'b1;
                  ow_ff[jj] <= '0;
               end else begin
                  st_ff[jj] <= st_ff[jj - IW'(1)];
                  sz_ff[jj] <= sz_ff[jj - IW'(1)];
                  fr_ff[jj] <= fr_ff[jj - IW'(1)];
                  ow_ff[jj] <= ow_ff[jj - IW'(1)];
                  j_ff <= j_ff - CW'(1);
               end
            end
            bfpa_pkg::ST_MERGE: begin
               if (j_ff != '0) begin
                  // move the tail down one slot per cycle over the absorbed entry
                  st_ff[jj] <= st_ff[jj + IW'(1)];
                  sz_ff[jj] <= sz_ff[jj + IW'(1)];
                  fr_ff[jj] <= fr_ff[jj + IW'(1)];
                  ow_ff[jj] <= ow_ff[jj + IW'(1)];
                  if (j_ff + CW'(1) >= cnt_ff) j_ff <= '0;
                  else                         j_ff <= j_ff + CW'(1);
               end else if (i_ff + CW'(1) < cnt_ff) begin
                  if (fr_ff[ii] && fr_ff[ii + IW'(1)]) begin
                     // absorb right neighbor and stay on i
                     sz_ff[ii] <= sz_ff[ii] + sz_ff[ii + IW'(1)];
                     cnt_ff <= cnt_ff - CW'(1);
                     if (i_ff + CW'(2) < cnt_ff) j_ff <= i_ff + CW'(1);
                  end else begin
                     i_ff <= i_ff + CW'(1);
                  end
               end
            end
            bfpa_pkg::ST_COMPACT: begin
               if (i_ff == cnt_ff) begin
                  oc_ff <= bfpa_pkg::RC_OK;
                  os_ff <= acc_ff;
                  if (msize_ff > acc_ff && j_ff != MAXC) begin
                     st_ff[jj] <= acc_ff;
                     sz_ff[jj] <= msize_ff - acc_ff;
                     fr_ff[jj] <= 1'b1;
                     ow_ff[jj] <= '0;
                     cnt_ff <= j_ff + CW'(1);
                     ol_ff <= msize_ff - acc_ff;
                     oh_ff <= 1'b1;
                  end else begin
                     cnt_ff <= j_ff;
                  end
               end else begin
                  i_ff <= i_ff + CW'(1);
                  if (!fr_ff[ii]) begin
                     st_ff[jj] <= acc_ff;
                     sz_ff[jj] <= sz_ff[ii];
                     fr_ff[jj] <= 1'b0;
                     ow_ff[jj] <= ow_ff[ii];
                     acc_ff <= acc_ff + sz_ff[ii];
                     j_ff <= j_ff + CW'(1);
                  end
               end
            end
            bfpa_pkg::ST_TOTAL: begin
               if (i_ff == cnt_ff) begin
                  i_ff <= '0;
               end else begin
                  i_ff <= i_ff + CW'(1);
                  if (fr_ff[ii]) fre_ff <= fre_ff + sz_ff[ii];
                  else           alc_ff <= alc_ff + sz_ff[ii];
               end
            end
            bfpa_pkg::ST_DUMP: begin
               if (out_free) begin
                  ov_ff <= 1'b1;
                  oc_ff <= bfpa_pkg::RC_OK;
                  os_ff <= st_ff[ii];
                  ol_ff <= sz_ff[ii];
                  oh_ff <= fr_ff[ii];
                  oo_ff <= ow_ff[ii];
                  oa_ff <= alc_ff;
                  of_ff <= fre_ff;
                  olast_ff <= (i_ff + CW'(1) == cnt_ff);
                  i_ff <= i_ff + CW'(1);
               end
            end
            bfpa_pkg::ST_EMIT: begin
               if (out_free) ov_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end
endmodule

@@ src/bfpa_checker.sv @@
`timescale 1ns / 1ps
module bfpa_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last,
   input logic [2:0] rsp_code
);
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_code <= bfpa_pkg::RC_FULL) else $error("bad code");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready during work");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_last))
      else $error("rsp dropped");
   a_norsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready with pending result");
endmodule

bind best_fit_partition_allocator bfpa_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_last(rsp.last),
   .rsp_code(rsp.result_code));

@@ verif/tb_best_fit_partition_allocator.sv @@
`timescale 1ns / 1ps
module tb_best_fit_partition_allocator;

   localparam int NBLK = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int IDLE_TAIL = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bfpa_req_if #(.AW(16), .OW(8)) req_ch ();
   bfpa_rsp_if #(.AW(16), .OW(8)) rsp_ch ();
   bfpa_csr_if #(.AW(16))         csr_ch ();

   best_fit_partition_allocator u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic [2:0]  code;
      logic [15:0] start;
      logic [15:0] length;
      logic        hole;
      logic [7:0]  holder;
      logic [15:0] alloc_sum;
      logic [15:0] free_sum;
      logic        last;
   } alloc_result_type;

   // Shadow allocation table, kept in step with every accepted transfer.
   logic [15:0] mem_bytes;
   logic [15:0] seg_start [NBLK];
   logic [15:0] seg_len   [NBLK];
   logic        seg_hole  [NBLK];
   logic [7:0]  seg_owner [NBLK];
   int          seg_count;

   alloc_result_type pending_results[$];
   int  error_count = 0;
   int  mismatch_count = 0;
   int  sender_idle_pct = 0;
   int  receiver_idle_pct = 0;
   bit  long_hold = 1'b0;
   int  quiet_cycles = 0;

   function automatic alloc_result_type fault(input bfpa_pkg::code_type c);
      alloc_result_type r;
      r = '0;
      r.code = c;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void table_clear();
      for (int i = 0; i < NBLK; i++) begin
         seg_start[i] = '0;
         seg_len[i] = '0;
         seg_hole[i] = 1'b0;
         seg_owner[i] = '0;
      end
      seg_len[0] = mem_bytes;
      seg_hole[0] = 1'b1;
      seg_count = 1;
   endfunction

   function automatic void drop_seg(input int idx);
      for (int j = idx; j + 1 < seg_count; j++) begin
         seg_start[j] = seg_start[j+1];
         seg_len[j] = seg_len[j+1];
         seg_hole[j] = seg_hole[j+1];
         seg_owner[j] = seg_owner[j+1];
      end
      seg_count--;
   endfunction

   // Work out the results of one command and update the shadow table.
   function automatic void predict_alloc(input bfpa_pkg::mode_type md,
                                         input logic [7:0] own, input logic [15:0] sz);
      alloc_result_type r;
      int best;
      logic [15:0] best_left;
      logic [15:0] addr;
      logic [15:0] rest;
      logic [15:0] asum;
      logic [15:0] fsum;
      int n;
      bit found;
      r = '0;
      r.last = 1'b1;
      best = 0;
      best_left = '0;
      found = 1'b0;
      case (md)
         bfpa_pkg::MODE_REQUEST: begin
            if (sz == 0) begin
               pending_results.push_back(fault(bfpa_pkg::RC_BAD_SIZE));
               return;
            end
            for (int i = 0; i < seg_count; i++) begin
               if (seg_hole[i] && seg_len[i] >= sz &&
                   (!found || seg_len[i] - sz < best_left)) begin
                  found = 1'b1;
                  best = i;
                  best_left = seg_len[i] - sz;
               end
            end
            if (!found) begin
               pending_results.push_back(fault(bfpa_pkg::RC_NO_FIT));
               return;
            end
            if (best_left != 0) begin
               if (seg_count >= NBLK) begin
                  pending_results.push_back(fault(bfpa_pkg::RC_FULL));
                  return;
               end
               for (int j = seg_count; j > best + 1; j--) begin
                  seg_start[j] = seg_start[j-1];
                  seg_len[j] = seg_len[j-1];
                  seg_hole[j] = seg_hole[j-1];
                  seg_owner[j] = seg_owner[j-1];
               end
               seg_start[best+1] = seg_start[best] + sz;
               seg_len[best+1] = best_left;
               seg_hole[best+1] = 1'b1;
               seg_owner[best+1] = '0;
               seg_count++;
               seg_len[best] = sz;
            end
            seg_hole[best] = 1'b0;
            seg_owner[best] = own;
            r.start = seg_start[best];
            r.length = sz;
            r.holder = own;
            pending_results.push_back(r);
         end
         bfpa_pkg::MODE_RELEASE: begin
            for (int i = 0; i < seg_count; i++) begin
               if (!seg_hole[i] && seg_owner[i] == own) begin
                  r.start = seg_start[i];
                  r.length = seg_len[i];
                  r.hole = 1'b1;
                  seg_hole[i] = 1'b1;
                  seg_owner[i] = '0;
                  n = 0;
                  while (n + 1 < seg_count) begin
                     if (seg_hole[n] && seg_hole[n+1]) begin
                        seg_len[n] = seg_len[n] + seg_len[n+1];
                        drop_seg(n + 1);
                     end else begin
                        n++;
                     end
                  end
                  pending_results.push_back(r);
                  return;
               end
            end
            pending_results.push_back(fault(bfpa_pkg::RC_NO_OWNER));
         end
         bfpa_pkg::MODE_COMPACT: begin
            n = 0;
            addr = '0;
            for (int i = 0; i < seg_count; i++) begin
               if (!seg_hole[i]) begin
                  seg_start[n] = addr;
                  seg_len[n] = seg_len[i];
                  seg_hole[n] = 1'b0;
                  seg_owner[n] = seg_owner[i];
                  addr = addr + seg_len[i];
                  n++;
               end
            end
            rest = (mem_bytes > addr) ? mem_bytes - addr : 16'd0;
            if (rest > 0 && n < NBLK) begin
               seg_start[n] = addr;
               seg_len[n] = rest;
               seg_hole[n] = 1'b1;
               seg_owner[n] = '0;
               n++;
            end else begin
               rest = '0;
            end
            seg_count = n;
            r.start = addr;
            r.length = rest;
            r.hole = (rest > 0);
            pending_results.push_back(r);
         end
         default: begin
            asum = '0;
            fsum = '0;
            for (int i = 0; i < seg_count; i++) begin
               if (seg_hole[i]) fsum = fsum + seg_len[i];
               else asum = asum + seg_len[i];
            end
            for (int i = 0; i < seg_count; i++) begin
               r.start = seg_start[i];
               r.length = seg_len[i];
               r.hole = seg_hole[i];
               r.holder = seg_owner[i];
               r.alloc_sum = asum;
               r.free_sum = fsum;
               r.last = (i + 1 == seg_count);
               pending_results.push_back(r);
            end
         end
      endcase
   endfunction

   // Directed rows; a typed-in expectation is used where has_expect is set.
   typedef struct {
      bfpa_pkg::mode_type md;
      logic [7:0]         own;
      logic [15:0]        sz;
      bit                 has_expect;
      alloc_result_type   want;
   } cmd_row_type;

   cmd_row_type directed[$];
   // Typed-in expectations for the directed rows that carry one.
   alloc_result_type typed_results[$];
   bit typed_flags[$];

   // Drive one command at a falling edge and return at the accepting rising edge.
   task automatic send_cmd(input bfpa_pkg::mode_type md, input logic [7:0] own,
                           input logic [15:0] sz);
      @(negedge clock);
      while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= md;
      req_ch.owner_id <= own;
      req_ch.request_size <= sz;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_alloc(md, own, sz);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Write memory_size while the block is idle; a zero write must be ignored.
   task automatic write_mem_size(input logic [15:0] v);
      wait_drained();
      repeat (IDLE_TAIL) @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      if (v != 0) begin
         mem_bytes = v;
         table_clear();
      end
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic cmd_row_type row(input bfpa_pkg::mode_type md, input logic [7:0] own,
                                       input logic [15:0] sz);
      cmd_row_type c;
      c.md = md;
      c.own = own;
      c.sz = sz;
      c.has_expect = 1'b0;
      c.want = '0;
      return c;
   endfunction

   function automatic cmd_row_type row_exp(input bfpa_pkg::mode_type md,
                                           input logic [7:0] own, input logic [15:0] sz,
                                           input alloc_result_type w);
      cmd_row_type c;
      c = row(md, own, sz);
      c.has_expect = 1'b1;
      c.want = w;
      return c;
   endfunction

   function automatic alloc_result_type okr(input logic [15:0] st, input logic [15:0] ln,
                                            input logic hl, input logic [7:0] ow);
      alloc_result_type r;
      r = '0;
      r.start = st;
      r.length = ln;
      r.hole = hl;
      r.holder = ow;
      r.last = 1'b1;
      return r;
   endfunction

   // Check every result transfer against the oldest expectation.
   always @(posedge clock) begin
      alloc_result_type got;
      alloc_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.code = rsp_ch.result_code;
         got.start = rsp_ch.block_start;
         got.length = rsp_ch.block_length;
         got.hole = rsp_ch.block_is_hole;
         got.holder = rsp_ch.block_holder;
         got.alloc_sum = rsp_ch.alloc_bytes;
         got.free_sum = rsp_ch.hole_bytes;
         got.last = rsp_ch.last;
         if (pending_results.size() == 0) begin
            error_count++;
            if (mismatch_count++ < 10) $display("unexpected result %p", got);
         end else begin
            want = pending_results.pop_front();
            if (typed_flags.size() != 0) begin
               // Directed row with a hand-written value: it must agree too.
               if (typed_flags[0] && typed_results[0] !== got) begin
                  error_count++;
                  if (mismatch_count++ < 10)
                     $display("directed row: expected %p, actual %p", typed_results[0], got);
               end
               // Advance to the next row on the final result of this one.
               if (got.last) begin
                  if (typed_flags.pop_front()) void'(typed_results.pop_front());
               end
            end
            if (got !== want) begin
               error_count++;
               if (mismatch_count++ < 10)
                  $display("mismatch: expected %p, actual %p", want, got);
            end
         end
      end
   end

   // Receiver: random stall, plus one long hold-off counted here.
   always @(negedge clock) begin
      int hold_left;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
      end else if (long_hold && hold_left == 0 && rsp_ch.valid) begin
         hold_left = 300;
         long_hold = 1'b0;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
      end
   end

   // Watchdog: count cycles without any transfer.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic random_phase(input int count);
      int pick;
      logic [7:0] own;
      logic [15:0] sz;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99, 0);
         own = 8'($urandom_range(7, 0));
         if ($urandom_range(9, 0) == 0) own = 8'($urandom);
         case ($urandom_range(3, 0))
            0: sz = 16'($urandom_range(64, 1));
            1: sz = 16'($urandom_range(mem_bytes / 4 + 1, 1));
            2: sz = 16'($urandom);
            default: sz = 16'($urandom_range(mem_bytes, 0));
         endcase
         if (pick < 50)      send_cmd(bfpa_pkg::MODE_REQUEST, own, sz);
         else if (pick < 78) send_cmd(bfpa_pkg::MODE_RELEASE, own, sz);
         else if (pick < 88) send_cmd(bfpa_pkg::MODE_COMPACT, own, 16'($urandom));
         else                send_cmd(bfpa_pkg::MODE_STATUS, own, 16'($urandom));
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = bfpa_pkg::MODE_REQUEST;
      req_ch.owner_id = '0;
      req_ch.request_size = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      mem_bytes = bfpa_pkg::MEM_SIZE_RESET;
      table_clear();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table on the reset size of 65535 bytes.
      directed.push_back(row_exp(bfpa_pkg::MODE_STATUS, 8'd0, 16'd0,
         '{code: bfpa_pkg::RC_OK, start: 16'd0, length: 16'hFFFF, hole: 1'b1,
           holder: 8'd0, alloc_sum: 16'd0, free_sum: 16'hFFFF, last: 1'b1}));
      directed.push_back(row_exp(bfpa_pkg::MODE_REQUEST, 8'd1, 16'd0,
         fault(bfpa_pkg::RC_BAD_SIZE)));
      directed.push_back(row_exp(bfpa_pkg::MODE_RELEASE, 8'd9, 16'd0,
         fault(bfpa_pkg::RC_NO_OWNER)));
      directed.push_back(row_exp(bfpa_pkg::MODE_REQUEST, 8'd0, 16'd100,
         okr(16'd0, 16'd100, 1'b0, 8'd0)));
      directed.push_back(row_exp(bfpa_pkg::MODE_REQUEST, 8'd255, 16'hFFFF,
         fault(bfpa_pkg::RC_NO_FIT)));
      directed.push_back(row(bfpa_pkg::MODE_REQUEST, 8'd2, 16'd200));
      directed.push_back(row(bfpa_pkg::MODE_REQUEST, 8'd3, 16'd50));
      directed.push_back(row(bfpa_pkg::MODE_RELEASE, 8'd2, 16'd0));
      directed.push_back(row(bfpa_pkg::MODE_REQUEST, 8'd4, 16'd150));
      directed.push_back(row(bfpa_pkg::MODE_RELEASE, 8'd0, 16'hFFFF));
      directed.push_back(row(bfpa_pkg::MODE_STATUS, 8'd0, 16'd0));
      directed.push_back(row(bfpa_pkg::MODE_COMPACT, 8'd0, 16'd0));
      directed.push_back(row(bfpa_pkg::MODE_STATUS, 8'd0, 16'd0));
      directed.push_back(row_exp(bfpa_pkg::MODE_REQUEST, 8'hAA, 16'h5555,
         okr(16'd200, 16'h5555, 1'b0, 8'hAA)));
      directed.push_back(row(bfpa_pkg::MODE_RELEASE, 8'hAA, 16'hAAAA));
      directed.push_back(row(bfpa_pkg::MODE_RELEASE, 8'd3, 16'd0));
      directed.push_back(row(bfpa_pkg::MODE_RELEASE, 8'd4, 16'd0));
      foreach (directed[i]) begin
         typed_flags.push_back(directed[i].has_expect);
         if (directed[i].has_expect) typed_results.push_back(directed[i].want);
         send_cmd(directed[i].md, directed[i].own, directed[i].sz);
         wait_drained();
      end
      typed_flags.delete();

      // Fill the table with tiny blocks so a split hits the table-full case,
      // then exact fit, then compaction of a full memory.
      write_mem_size(16'd20);
      for (int i = 0; i < 15; i++) send_cmd(bfpa_pkg::MODE_REQUEST, 8'(i + 10), 16'd1);
      send_cmd(bfpa_pkg::MODE_RELEASE, 8'd12, 16'd0);
      send_cmd(bfpa_pkg::MODE_REQUEST, 8'd40, 16'd2);
      send_cmd(bfpa_pkg::MODE_REQUEST, 8'd41, 16'd1);
      send_cmd(bfpa_pkg::MODE_REQUEST, 8'd42, 16'd5);
      send_cmd(bfpa_pkg::MODE_COMPACT, 8'd0, 16'd0);
      send_cmd(bfpa_pkg::MODE_STATUS, 8'd0, 16'd0);
      write_mem_size(16'd0);
      send_cmd(bfpa_pkg::MODE_STATUS, 8'd0, 16'd0);

      // Random part: three idling profiles over several memory sizes.
      write_mem_size(16'd1);
      send_cmd(bfpa_pkg::MODE_REQUEST, 8'd1, 16'd1);
      send_cmd(bfpa_pkg::MODE_COMPACT, 8'd0, 16'd0);
      sender_idle_pct = 14;
      receiver_idle_pct = 75;
      write_mem_size(16'd256);
      long_hold = 1'b1;
      random_phase(56);
      wait_drained();
      sender_idle_pct = 75;
      receiver_idle_pct = 14;
      write_mem_size(16'hFFFF);
      random_phase(56);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_mem_size(16'd1000);
      random_phase(56);

      wait_drained();
      repeat (IDLE_TAIL) @(negedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
